// ===== rtl/core/ntps_pkg.sv =====
// Shared types, widths and codes of the nearest-two point search block.
package ntps_pkg;

  localparam int DEPTH_DEF = 4096;
  localparam int COORD_W   = 24;
  localparam int SLOT_W    = 12;
  localparam int RAD_W     = 12;
  localparam int CNT_W     = 13;
  localparam int DIST_W    = 52;
  localparam int ROOT_W    = DIST_W / 2;
  localparam int SQ_W      = 2 * COORD_W;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic MODE_SQUARED = 1'b0;
  localparam logic MODE_SIZED   = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RAD_W-1:0]          item_radius;
    logic [CNT_W-1:0]          search_count;
  } ntps_req_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] best_distance;
    logic signed [DIST_W-1:0] second_distance;
    logic [SLOT_W-1:0]        nearest_index;
    logic                     second_found;
  } ntps_res_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RAD_W-1:0]   r;
  } ntps_point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQX,
    S_SQY,
    S_SUM,
    S_ROOT,
    S_CMP
  } ntps_state_e;

endpackage

// ===== rtl/core/nearest_two_point_search_top.sv =====
// Top level: command sequencer walking the point table with one shared multiplier.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  request  | in        | start, busy            | req_i (ntps_req_t)
//  result   | out       | done_o strobe, 1 cycle | res_o (ntps_res_t)
//  config   | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (mode bit)
//
// A store writes its slot. A query walks each slot through read, square x, square y,
// sum and compare, with a wait on the square root unit between sum and compare in
// corrected mode, over the clamped count, and ends with the done strobe.
// Reset clears control and the mode register; the table is not cleared.
// The receiver cannot stall: done_o is a one-cycle strobe with res_o valid.
// Config writes are taken only while busy is low.
module nearest_two_point_search_top #(
  parameter int TABLE_DEPTH = ntps_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ntps_pkg::ntps_req_t req_i,
  output logic               done_o,
  output ntps_pkg::ntps_res_t res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KW  = (AW + 1 > ntps_pkg::CNT_W) ? AW + 1 : ntps_pkg::CNT_W;
  localparam int CWD = ntps_pkg::COORD_W;
  localparam int DW  = ntps_pkg::DIST_W;
  localparam int SW  = ntps_pkg::SQ_W;

  ntps_pkg::ntps_state_e state_q, state_d;

  logic                   mode_q;
  logic signed [CWD-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic [ntps_pkg::RAD_W-1:0] qr_q, qr_d;
  logic [KW-1:0]          n_q, n_d, k_q, k_d;
  logic [SW-1:0]          sqx_q, sqx_d, sqy_q, sqy_d;
  logic [DW-1:0]          sum_q, sum_d;
  logic signed [DW-1:0]   best_q, best_d, second_q, second_d;
  logic [ntps_pkg::SLOT_W-1:0] near_q, near_d;
  logic                   have1_q, have1_d, have2_q, have2_d;
  logic                   done_q, done_d;

  logic                   accept;
  logic                   wr_en;
  logic [KW-1:0]          slot_ext;
  logic [KW-1:0]          cnt_ext;
  ntps_pkg::ntps_point_t  wr_point;
  ntps_pkg::ntps_point_t  rd_point;
  logic                   rd_en;
  logic signed [CWD:0]    dif;
  logic [CWD-1:0]         mag;
  logic [SW-1:0]          prod;
  logic [DW-1:0]          sum_w;
  logic                   root_start;
  logic                   root_done;
  logic [ntps_pkg::ROOT_W-1:0] root;
  logic signed [DW-1:0]   cand_dist;

  assign accept      = start && !busy;
  assign busy        = (state_q != ntps_pkg::S_IDLE);
  assign cfg_ready_o = !busy;

  // Store path: write the slot on transfer when it lies in the table
  assign slot_ext   = KW'(req_i.slot);
  assign cnt_ext    = KW'(req_i.search_count);
  assign wr_en      = accept && (req_i.req_type == ntps_pkg::REQ_STORE)
                      && (slot_ext < KW'(TABLE_DEPTH));
  assign wr_point.x = req_i.pos_x;
  assign wr_point.y = req_i.pos_y;
  assign wr_point.r = req_i.item_radius;
  assign rd_en      = (state_q == ntps_pkg::S_READ);

  ntps_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_ext[AW-1:0]),
    .wr_data_i (wr_point),
    .rd_en_i   (rd_en),
    .rd_addr_i (k_q[AW-1:0]),
    .rd_data_o (rd_point)
  );

  // Shared multiplier: squares |dx| then |dy|
  always_comb begin
    if (state_q == ntps_pkg::S_SQX) begin
      dif = {qx_q[CWD-1], qx_q} - {rd_point.x[CWD-1], rd_point.x};
    end else begin
      dif = {qy_q[CWD-1], qy_q} - {rd_point.y[CWD-1], rd_point.y};
    end
    if (dif[CWD]) begin
      mag = CWD'(-dif);
    end else begin
      mag = dif[CWD-1:0];
    end
    prod = mag * mag;
  end

  // Squares of 24-bit magnitudes sum without overflow in the 52-bit distance width
  assign sum_w      = DW'(sqx_q) + DW'(sqy_q);
  assign root_start = (state_q == ntps_pkg::S_SUM) && (mode_q == ntps_pkg::MODE_SIZED);

  ntps_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_w),
    .done_o     (root_done),
    .root_o     (root)
  );

  // Candidate distance for the current slot
  always_comb begin
    if (mode_q == ntps_pkg::MODE_SIZED) begin
      cand_dist = $signed(DW'(root)) - $signed(DW'(qr_q)) - $signed(DW'(rd_point.r));
    end else begin
      cand_dist = $signed(sum_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    qx_d     = qx_q;
    qy_d     = qy_q;
    qr_d     = qr_q;
    n_d      = n_q;
    k_d      = k_q;
    sqx_d    = sqx_q;
    sqy_d    = sqy_q;
    sum_d    = sum_q;
    best_d   = best_q;
    second_d = second_q;
    near_d   = near_q;
    have1_d  = have1_q;
    have2_d  = have2_q;
    done_d   = 1'b0;
    case (state_q)
      ntps_pkg::S_IDLE: begin
        if (accept && (req_i.req_type == ntps_pkg::REQ_QUERY) && (cnt_ext != '0)) begin
          qx_d    = req_i.pos_x;
          qy_d    = req_i.pos_y;
          qr_d    = req_i.item_radius;
          n_d     = (cnt_ext > KW'(TABLE_DEPTH)) ? KW'(TABLE_DEPTH) : cnt_ext;
          k_d     = '0;
          have1_d = 1'b0;
          have2_d = 1'b0;
          state_d = ntps_pkg::S_READ;
        end
      end
      ntps_pkg::S_READ: begin
        state_d = ntps_pkg::S_SQX;
      end
      ntps_pkg::S_SQX: begin
        sqx_d   = prod;
        state_d = ntps_pkg::S_SQY;
      end
      ntps_pkg::S_SQY: begin
        sqy_d   = prod;
        state_d = ntps_pkg::S_SUM;
      end
      ntps_pkg::S_SUM: begin
        sum_d = sum_w;
        if (mode_q == ntps_pkg::MODE_SIZED) begin
          state_d = ntps_pkg::S_ROOT;
        end else begin
          state_d = ntps_pkg::S_CMP;
        end
      end
      ntps_pkg::S_ROOT: begin
        if (root_done) begin
          state_d = ntps_pkg::S_CMP;
        end
      end
      ntps_pkg::S_CMP: begin
        // Strict compares keep the earlier slot on ties
        if (!have2_q || (cand_dist < second_q)) begin
          if (!have1_q || (cand_dist < best_q)) begin
            second_d = best_q;
            have2_d  = have1_q;
            best_d   = cand_dist;
            have1_d  = 1'b1;
            near_d   = k_q[ntps_pkg::SLOT_W-1:0];
          end else begin
            second_d = cand_dist;
            have2_d  = 1'b1;
          end
        end
        if (k_q + 1'b1 == n_q) begin
          done_d  = 1'b1;
          state_d = ntps_pkg::S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ntps_pkg::S_READ;
        end
      end
      default: begin
        state_d = ntps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntps_pkg::S_IDLE;
      mode_q  <= ntps_pkg::MODE_SQUARED;
      done_q  <= 1'b0;
      have1_q <= 1'b0;
      have2_q <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      have1_q <= have1_d;
      have2_q <= have2_d;
      k_q     <= k_d;
      n_q     <= n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    qx_q     <= qx_d;
    qy_q     <= qy_d;
    qr_q     <= qr_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
    sum_q    <= sum_d;
    best_q   <= best_d;
    second_q <= second_d;
    near_q   <= near_d;
  end

  // Result: hold sentinel when no second distance
  assign done_o                = done_q;
  assign res_o.best_distance   = best_q;
  assign res_o.second_distance = have2_q ? second_q : '1;
  assign res_o.nearest_index   = near_q;
  assign res_o.second_found    = have2_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ntps_pkg::S_IDLE))
    else $error("result strobe outside idle");

  a_have_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have2_q |-> have1_q)
    else $error("second distance without a best one");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have2_q && !busy) |-> (best_q <= second_q))
    else $error("best distance above second distance");

  a_cmp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntps_pkg::S_CMP) |-> (k_q < n_q))
    else $error("slot counter past clamped count");

endmodule

// ===== rtl/core/ntps_store.sv =====
// Point table: one write port, one registered read port.
module ntps_store #(
  parameter int TABLE_DEPTH = ntps_pkg::DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  ntps_pkg::ntps_point_t wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output ntps_pkg::ntps_point_t rd_data_o
);

  ntps_pkg::ntps_point_t mem [TABLE_DEPTH];
  ntps_pkg::ntps_point_t rd_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one slot, hold data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/ntps_isqrt.sv =====
// Integer floor square root, two radicand bits per cycle.
module ntps_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ntps_pkg::DIST_W-1:0]   radicand_i,
  output logic                          done_o,
  output logic [ntps_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW = ntps_pkg::ROOT_W;
  localparam int DW = ntps_pkg::DIST_W;
  localparam int CW = $clog2(RW + 1);

  logic [DW-1:0] rad_q, rad_d;
  logic [RW+1:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;

  // One restoring step per cycle
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RW-1:0], rad_q[DW-1:DW-2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d = {rad_q[DW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(RW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
